// ===== rtl/ebaq_pkg.sv =====
`default_nettype none

package ebaq_pkg;

	// Fixed field widths of the request and configuration ports.
	localparam int ENC_W     = 32;
	localparam int NOW_W     = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int ACT_W     = 3;

	// Default widths of the stored count and time.
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TIME_WIDTH_DEF  = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd3000;

	// Action codes.
	typedef enum logic [ACT_W-1:0] {
		ACT_NONE   = 3'd0,
		ACT_CW     = 3'd1,
		ACT_CCW    = 3'd2,
		ACT_SELECT = 3'd3,
		ACT_HOLD   = 3'd4
	} action_t;

	// Configuration handed to the qualifier.
	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] hold_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/encoder_button_action_qualifier.sv =====
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        to block   in_valid / in_ready      encoder_count, button_level, now_ms
// out       from block out_valid / out_ready    action
// cfg       to block   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request may be accepted every cycle unless both registers are full and the result
// is stalled; its action, formed by the qualifier logic between the two registers, is
// loaded into the result register once the input register holds it and the result register frees.
// A stalled result holds in the result register while one more request waits in
// the input register; the block keeps accepting as long as either has room.
// Reset empties both registers and returns the qualifier state and the
// configuration to their reset values.
module encoder_button_action_qualifier #(
	parameter int COUNT_WIDTH = ebaq_pkg::COUNT_WIDTH_DEF,
	parameter int TIME_WIDTH  = ebaq_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ebaq_pkg::ENC_W-1:0]      encoder_count,
	input  wire logic                            button_level,
	input  wire logic [ebaq_pkg::NOW_W-1:0]      now_ms,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ebaq_pkg::ACT_W-1:0]           action,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ebaq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ebaq_pkg::CFG_W-1:0]      cfg_data
);
	import ebaq_pkg::*;

	logic              v_s1;
	logic [ENC_W-1:0]  enc_s1;
	logic              lvl_s1;
	logic [NOW_W-1:0]  now_s1;
	logic              v_s2;
	action_t           action_s2;
	cfg_t              cfg_q;
	action_t           action_next;
	logic              adv;

	// The request in the input register moves on when the result register frees.
	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign out_valid = v_s2;
	assign action    = action_s2;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.hold_ms     <= HOLD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data;
				CFG_HOLD:     cfg_q.hold_ms     <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			enc_s1 <= encoder_count;
			lvl_s1 <= button_level;
			now_s1 <= now_ms;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || out_ready) begin
			v_s2 <= v_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			action_s2 <= action_next;
		end
	end

	ebaq_qual #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_qual (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg_q),
		.enc_count   (enc_s1),
		.level       (lvl_s1),
		.now_raw     (now_s1),
		.action_next (action_next)
	);

endmodule

`default_nettype wire

// ===== rtl/ebaq_qual.sv =====
`default_nettype none

module ebaq_qual #(
	parameter int COUNT_WIDTH = ebaq_pkg::COUNT_WIDTH_DEF,
	parameter int TIME_WIDTH  = ebaq_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire ebaq_pkg::cfg_t              cfg,
	input  wire logic [ebaq_pkg::ENC_W-1:0]  enc_count,
	input  wire logic                        level,
	input  wire logic [ebaq_pkg::NOW_W-1:0]  now_raw,
	output ebaq_pkg::action_t                action_next
);
	import ebaq_pkg::*;

	logic [COUNT_WIDTH-1:0] last_count_q;
	logic [TIME_WIDTH-1:0]  debounce_start_q;
	logic                   prev_raw_q;
	logic                   stable_q;
	logic [TIME_WIDTH-1:0]  press_start_q;

	logic [63:0]            cnt_ext;
	logic [63:0]            now_ext;
	logic [63:0]            dbn_ext;
	logic [63:0]            hold_ext;
	logic [COUNT_WIDTH-1:0] cnt;
	logic [TIME_WIDTH-1:0]  now_t;
	logic [TIME_WIDTH-1:0]  dbn_t;
	logic [TIME_WIDTH-1:0]  hold_t;
	logic [TIME_WIDTH-1:0]  eff_start;
	logic [TIME_WIDTH-1:0]  elapsed;
	logic [TIME_WIDTH-1:0]  pressed_for;
	logic                   cnt_up;
	logic                   cnt_down;
	logic                   raw_change;
	logic                   settle;

	// Sign-extend the count and zero-extend the times, then trim to the stored widths.
	assign cnt_ext  = {{(64-ENC_W){enc_count[ENC_W-1]}}, enc_count};
	assign now_ext  = {{(64-NOW_W){1'b0}}, now_raw};
	assign dbn_ext  = {{(64-CFG_W){1'b0}}, cfg.debounce_ms};
	assign hold_ext = {{(64-CFG_W){1'b0}}, cfg.hold_ms};
	assign cnt      = cnt_ext[COUNT_WIDTH-1:0];
	assign now_t    = now_ext[TIME_WIDTH-1:0];
	assign dbn_t    = dbn_ext[TIME_WIDTH-1:0];
	assign hold_t   = hold_ext[TIME_WIDTH-1:0];

	// Rotation direction from a signed compare against the last count.
	assign cnt_up   = $signed(cnt) > $signed(last_count_q);
	assign cnt_down = $signed(cnt) < $signed(last_count_q);

	// A raw level change restarts the debounce window at this poll.
	assign raw_change  = level != prev_raw_q;
	assign eff_start   = raw_change ? now_t : debounce_start_q;
	assign elapsed     = now_t - eff_start;
	assign settle      = (elapsed > dbn_t) && (level != stable_q);
	assign pressed_for = now_t - press_start_q;

	// Action selection; button actions take priority over rotation.
	always_comb begin
		action_next = ACT_NONE;
		if (cnt_up) begin
			action_next = ACT_CW;
		end else if (cnt_down) begin
			action_next = ACT_CCW;
		end
		if (settle) begin
			if (!level) begin
				action_next = ACT_SELECT;
			end else if (pressed_for >= hold_t) begin
				action_next = ACT_HOLD;
			end
		end
	end

	// State update for each request that moves through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q     <= '0;
			debounce_start_q <= '0;
			prev_raw_q       <= 1'b1;
			stable_q         <= 1'b1;
			press_start_q    <= '0;
		end else if (adv) begin
			if (cnt_up || cnt_down) begin
				last_count_q <= cnt;
			end
			debounce_start_q <= eff_start;
			prev_raw_q       <= level;
			if (settle) begin
				stable_q      <= level;
				press_start_q <= level ? '0 : now_t;
			end
		end
	end

`ifndef ASSERT_OFF
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(stable_q) && $stable(last_count_q) && $stable(press_start_q))
		else $error("qualifier state changed without a request");

	a_select_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_next == ACT_SELECT |=> !stable_q)
		else $error("select issued but stable level not pressed");

	a_hold_released: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_next == ACT_HOLD |=> stable_q && press_start_q == '0)
		else $error("select-hold issued but release not taken over");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && raw_change |=> debounce_start_q == $past(now_t))
		else $error("debounce window not restarted on raw level change");
`endif

endmodule

`default_nettype wire
